[hw/rtl/ipim_pkg.sv]
// Shared types, constants and saturation helper for the image point
// interaction matrix pipeline. No dependencies.
package ipim_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IN_W      = 3 * DATA_W;
    localparam int OUT_W     = 10 * DATA_W;

    // Long division: 31 quotient bits, one per stage, plus a setup and a result stage.
    localparam int QUO_W    = 31;
    localparam int NUM_W    = DATA_W + FRAC_BITS;
    localparam int DEN_SH   = 31 - FRAC_BITS;
    localparam int BIG_W    = 31 + DEN_SH;
    localparam int BIG_PAD  = BIG_W - DATA_W;
    localparam int INIT_PAD = QUO_W - (NUM_W - QUO_W);
    localparam int DIV_LAT  = QUO_W + 2;
    localparam int LINE_B   = DIV_LAT - 2;
    localparam int PIPE_LAT = 2 * DIV_LAT + 1;

    localparam logic signed [DATA_W-1:0] NEG_ONE = -(32'sd1 <<< FRAC_BITS);
    localparam logic signed [65:0] W_ONE = 66'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] W_MAX = 66'sd2147483647;
    localparam logic signed [65:0] W_MIN = -66'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] u_ang_x;
        logic signed [DATA_W-1:0] u_ang_y;
        logic signed [DATA_W-1:0] u_ang_z;
        logic signed [DATA_W-1:0] v_ang_x;
        logic signed [DATA_W-1:0] v_ang_y;
        logic signed [DATA_W-1:0] v_ang_z;
    } t_prod;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > W_MAX) begin
            res = W_MAX[DATA_W-1:0];
        end else if (v < W_MIN) begin
            res = W_MIN[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/image_point_interaction_matrix.sv]
// Top level of the image point interaction matrix pipeline.
// Depends on ipim_pkg, ipim_div and ipim_prod.
//
// Usage:
//   Input stream (i_s_*): one word per feature point: x, y, depth in Q16.16.
//   Output stream (o_m_*): one word per point with the ten non-zero entries of
//   the 2x6 interaction matrix; o_m_tuser flags a depth at or below zero, and
//   then every entry is zero.
//   i_cfg_we / i_cfg_wdata write the camera point mode: 0 takes x, y as
//   normalized coordinates, 1 divides camera-frame X, Y by the depth first.
//   Write it only while no word is in flight.
// Timing:
//   The path from input acceptance to o_m_tvalid is two back-to-back
//   33-stage long dividers (one quotient bit per stage), the first for X/Z,
//   Y/Z, the second for x/Z, y/Z and -1/Z, plus the output register. One
//   word enters per cycle while the output is taken.
// Reset and stall:
//   Reset clears all valid bits and the mode register; payload holds garbage.
//   When the receiver stalls with a word waiting, the whole pipeline holds;
//   nothing is dropped or repeated, and input tready drops with it.
module image_point_interaction_matrix (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // point_x [31:0], point_y [63:32], depth [95:64]
    input  logic [ipim_pkg::IN_W-1:0]      i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // u_ang_x, u_ang_y, u_ang_z, u_lin_x, u_lin_z,
    // v_ang_x, v_ang_y, v_ang_z, v_lin_y, v_lin_z (32 bits each, from bit 0)
    output logic [ipim_pkg::OUT_W-1:0]     o_m_tdata,
    // depth_invalid [0]
    output logic                           o_m_tuser
);

    localparam int DW = ipim_pkg::DATA_W;

    logic w_en;
    logic r_mode;
    logic r_vld [0:ipim_pkg::PIPE_LAT-1];

    // Delay line alongside the first divider.
    logic signed [DW-1:0] r_la_x [0:ipim_pkg::DIV_LAT-1];
    logic signed [DW-1:0] r_la_y [0:ipim_pkg::DIV_LAT-1];
    logic signed [DW-1:0] r_la_z [0:ipim_pkg::DIV_LAT-1];
    logic                 r_la_inv [0:ipim_pkg::DIV_LAT-1];

    // Delay line alongside the second divider, ahead of the product unit.
    logic signed [DW-1:0] r_lb_x [0:ipim_pkg::LINE_B-1];
    logic signed [DW-1:0] r_lb_y [0:ipim_pkg::LINE_B-1];
    logic                 r_lb_inv [0:ipim_pkg::LINE_B-1];
    logic                 r_inv_p [0:1];

    logic signed [DW-1:0] w_in_x;
    logic signed [DW-1:0] w_in_y;
    logic signed [DW-1:0] w_in_z;
    logic signed [DW-1:0] w_qa_x;
    logic signed [DW-1:0] w_qa_y;
    logic signed [DW-1:0] w_sel_x;
    logic signed [DW-1:0] w_sel_y;
    logic signed [DW-1:0] w_qb_x;
    logic signed [DW-1:0] w_qb_y;
    logic signed [DW-1:0] w_qb_inv;
    ipim_pkg::t_prod      w_prod;

    logic [ipim_pkg::OUT_W-1:0] n_tdata;
    logic                       n_tuser;

    // Advance everything when the output register is empty or being taken.
    assign w_en       = ~o_m_tvalid | i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[ipim_pkg::PIPE_LAT-1];

    assign w_in_x = i_s_tdata[DW-1:0];
    assign w_in_y = i_s_tdata[2*DW-1:DW];
    assign w_in_z = i_s_tdata[3*DW-1:2*DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ipim_pkg::PIPE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < ipim_pkg::PIPE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // First pass: camera-frame X/Z and Y/Z.
    ipim_div u_div_ax (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_in_x),
        .i_den (w_in_z),
        .o_quo (w_qa_x)
    );

    ipim_div u_div_ay (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_in_y),
        .i_den (w_in_z),
        .o_quo (w_qa_y)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_la_x[0]   <= w_in_x;
            r_la_y[0]   <= w_in_y;
            r_la_z[0]   <= w_in_z;
            r_la_inv[0] <= (w_in_z[DW-1] | (w_in_z == '0));
            for (int k = 1; k < ipim_pkg::DIV_LAT; k++) begin
                r_la_x[k]   <= r_la_x[k-1];
                r_la_y[k]   <= r_la_y[k-1];
                r_la_z[k]   <= r_la_z[k-1];
                r_la_inv[k] <= r_la_inv[k-1];
            end
        end
    end

    // Pick the point the matrix is built from.
    assign w_sel_x = r_mode ? w_qa_x : r_la_x[ipim_pkg::DIV_LAT-1];
    assign w_sel_y = r_mode ? w_qa_y : r_la_y[ipim_pkg::DIV_LAT-1];

    // Second pass: x/Z, y/Z and -1/Z.
    ipim_div u_div_bx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_sel_x),
        .i_den (r_la_z[ipim_pkg::DIV_LAT-1]),
        .o_quo (w_qb_x)
    );

    ipim_div u_div_by (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_sel_y),
        .i_den (r_la_z[ipim_pkg::DIV_LAT-1]),
        .o_quo (w_qb_y)
    );

    ipim_div u_div_inv (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (ipim_pkg::NEG_ONE),
        .i_den (r_la_z[ipim_pkg::DIV_LAT-1]),
        .o_quo (w_qb_inv)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lb_x[0]   <= w_sel_x;
            r_lb_y[0]   <= w_sel_y;
            r_lb_inv[0] <= r_la_inv[ipim_pkg::DIV_LAT-1];
            for (int k = 1; k < ipim_pkg::LINE_B; k++) begin
                r_lb_x[k]   <= r_lb_x[k-1];
                r_lb_y[k]   <= r_lb_y[k-1];
                r_lb_inv[k] <= r_lb_inv[k-1];
            end
            r_inv_p[0] <= r_lb_inv[ipim_pkg::LINE_B-1];
            r_inv_p[1] <= r_inv_p[0];
        end
    end

    // Products land in step with the second divider.
    ipim_prod u_prod (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_lb_x[ipim_pkg::LINE_B-1]),
        .i_y   (r_lb_y[ipim_pkg::LINE_B-1]),
        .o_res (w_prod)
    );

    // Zero the entries on a bad depth.
    always_comb begin
        n_tuser = r_inv_p[1];
        if (r_inv_p[1]) begin
            n_tdata = '0;
        end else begin
            n_tdata = {w_qb_y, w_qb_inv, w_prod.v_ang_z, w_prod.v_ang_y,
                       w_prod.v_ang_x, w_qb_x, w_qb_inv, w_prod.u_ang_z,
                       w_prod.u_ang_y, w_prod.u_ang_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_m_tdata <= n_tdata;
            o_m_tuser <= n_tuser;
        end
    end

endmodule

[hw/rtl/ipim_div.sv]
// Pipelined signed fixed-point divider: (num * 2^FRAC_BITS) / den, truncated, saturated.
// One quotient bit per stage; depends on ipim_pkg.
module ipim_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [ipim_pkg::DATA_W-1:0]  i_num,
    input  logic signed [ipim_pkg::DATA_W-1:0]  i_den,
    output logic signed [ipim_pkg::DATA_W-1:0]  o_quo
);

    logic [ipim_pkg::DATA_W-1:0] w_mag;
    logic [ipim_pkg::NUM_W-1:0]  w_dvd;
    logic                        w_big;

    logic [ipim_pkg::QUO_W-1:0] r_rem [0:ipim_pkg::QUO_W];
    logic [ipim_pkg::QUO_W-1:0] r_dvd [0:ipim_pkg::QUO_W];
    logic [ipim_pkg::QUO_W-1:0] r_quo [0:ipim_pkg::QUO_W];
    logic [ipim_pkg::QUO_W-1:0] r_den [0:ipim_pkg::QUO_W];
    logic                       r_neg [0:ipim_pkg::QUO_W];
    logic                       r_big [0:ipim_pkg::QUO_W];

    logic [ipim_pkg::QUO_W-1:0] n_rem [0:ipim_pkg::QUO_W-1];
    logic                       n_bit [0:ipim_pkg::QUO_W-1];

    logic [ipim_pkg::DATA_W-1:0] w_q32;
    logic signed [ipim_pkg::DATA_W-1:0] n_quo;

    // Setup: magnitude, scaled dividend, overflow test (quotient >= 2^31).
    always_comb begin
        w_mag = i_num[ipim_pkg::DATA_W-1] ? (~i_num + 32'd1) : i_num;
        w_dvd = {w_mag, {ipim_pkg::FRAC_BITS{1'b0}}};
        w_big = {{ipim_pkg::BIG_PAD{1'b0}}, w_mag}
                >= {i_den[ipim_pkg::QUO_W-1:0], {ipim_pkg::DEN_SH{1'b0}}};
    end

    // One restoring step per stage.
    always_comb begin
        for (int k = 0; k < ipim_pkg::QUO_W; k++) begin
            logic [ipim_pkg::QUO_W:0] trial;
            trial    = {r_rem[k], r_dvd[k][ipim_pkg::QUO_W-1]};
            n_bit[k] = trial >= {1'b0, r_den[k]};
            if (n_bit[k]) begin
                n_rem[k] = ipim_pkg::QUO_W'(trial - {1'b0, r_den[k]});
            end else begin
                n_rem[k] = trial[ipim_pkg::QUO_W-1:0];
            end
        end
    end

    always_comb begin
        w_q32 = {1'b0, r_quo[ipim_pkg::QUO_W]};
        if (r_big[ipim_pkg::QUO_W]) begin
            n_quo = r_neg[ipim_pkg::QUO_W] ? ipim_pkg::W_MIN[ipim_pkg::DATA_W-1:0]
                                           : ipim_pkg::W_MAX[ipim_pkg::DATA_W-1:0];
        end else begin
            n_quo = r_neg[ipim_pkg::QUO_W] ? (~w_q32 + 32'd1) : w_q32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {{ipim_pkg::INIT_PAD{1'b0}},
                         w_dvd[ipim_pkg::NUM_W-1:ipim_pkg::QUO_W]};
            r_dvd[0] <= w_dvd[ipim_pkg::QUO_W-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den[ipim_pkg::QUO_W-1:0];
            r_neg[0] <= i_num[ipim_pkg::DATA_W-1];
            r_big[0] <= w_big;
            for (int k = 0; k < ipim_pkg::QUO_W; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_dvd[k+1] <= {r_dvd[k][ipim_pkg::QUO_W-2:0], 1'b0};
                r_quo[k+1] <= {r_quo[k][ipim_pkg::QUO_W-2:0], n_bit[k]};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_big[k+1] <= r_big[k];
            end
            o_quo <= n_quo;
        end
    end

endmodule

[hw/rtl/ipim_prod.sv]
// Two-stage product unit: x*y, x*x, y*y, floor shift and saturation of the
// angular entries other than u_ang_z, which is y. Depends on ipim_pkg.
module ipim_prod (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [ipim_pkg::DATA_W-1:0] i_x,
    input  logic signed [ipim_pkg::DATA_W-1:0] i_y,
    output ipim_pkg::t_prod                    o_res
);

    logic signed [63:0] r_xy;
    logic signed [63:0] r_xx;
    logic signed [63:0] r_yy;
    logic signed [ipim_pkg::DATA_W-1:0] r_x;
    logic signed [ipim_pkg::DATA_W-1:0] r_y;

    logic signed [65:0] w_xy;
    logic signed [65:0] w_xx;
    logic signed [65:0] w_yy;
    logic signed [65:0] w_x;
    ipim_pkg::t_prod    n_res;

    // Arithmetic shift is floor division by 2^FRAC_BITS.
    always_comb begin
        w_xy = $signed({{2{r_xy[63]}}, r_xy}) >>> ipim_pkg::FRAC_BITS;
        w_xx = $signed({{2{r_xx[63]}}, r_xx}) >>> ipim_pkg::FRAC_BITS;
        w_yy = $signed({{2{r_yy[63]}}, r_yy}) >>> ipim_pkg::FRAC_BITS;
        w_x  = $signed({{34{r_x[31]}}, r_x});
        n_res.u_ang_x = ipim_pkg::sat32(w_xy);
        n_res.u_ang_y = ipim_pkg::sat32(-(ipim_pkg::W_ONE + w_xx));
        n_res.u_ang_z = r_y;
        n_res.v_ang_x = ipim_pkg::sat32(ipim_pkg::W_ONE + w_yy);
        n_res.v_ang_y = ipim_pkg::sat32(-w_xy);
        n_res.v_ang_z = ipim_pkg::sat32(-w_x);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xy  <= i_x * i_y;
            r_xx  <= i_x * i_x;
            r_yy  <= i_y * i_y;
            r_x   <= i_x;
            r_y   <= i_y;
            o_res <= n_res;
        end
    end

endmodule

[dv/tb_image_point_interaction_matrix.sv]
// Self-checking testbench for image_point_interaction_matrix: drives point words,
// predicts the ten matrix entries per point and checks every output word.
// Depends on ipim_pkg and the image_point_interaction_matrix RTL.
`timescale 1ns / 100ps

module tb_image_point_interaction_matrix;

    // Mode register values
    localparam logic MODE_NORMALIZED = 1'b0;
    localparam logic MODE_CAMERA     = 1'b1;

    localparam int           FRAC   = ipim_pkg::FRAC_BITS;
    localparam int           DW     = ipim_pkg::DATA_W;
    localparam logic [31:0]  Q_ONE  = 32'h0001_0000;
    localparam logic [31:0]  Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0]  Q_MIN  = 32'h8000_0000;
    localparam longint       W_MAX  = 64'sd2147483647;
    localparam longint       W_MIN  = -64'sd2147483648;

    // One expected output word: ten entries in port order plus the depth flag
    typedef struct packed {
        logic [9:0][DW-1:0] entry;
        logic               depth_invalid;
    } t_matrix_word;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic                          i_cfg_wdata = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    // point_x [31:0], point_y [63:32], depth [95:64]
    logic [ipim_pkg::IN_W-1:0]     i_s_tdata   = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    // u_ang_x, u_ang_y, u_ang_z, u_lin_x, u_lin_z,
    // v_ang_x, v_ang_y, v_ang_z, v_lin_y, v_lin_z (32 bits each, from bit 0)
    logic [ipim_pkg::OUT_W-1:0]    o_m_tdata;
    // depth_invalid [0]
    logic                          o_m_tuser;

    // Points waiting for the driver, and predicted matrices waiting for the DUT
    logic [ipim_pkg::IN_W-1:0]     point_q [$];
    t_matrix_word                  matrix_q [$];

    logic   mode_shadow   = MODE_NORMALIZED;
    logic   src_idle_en   = 1'b1;
    logic   snk_idle_en   = 1'b1;
    logic   point_taken   = 1'b0;
    logic   matrix_taken  = 1'b0;
    int     src_gap       = 0;
    int     snk_stall     = 0;
    int     mismatch_cnt  = 0;

    string entry_name [10] = '{"u_ang_x", "u_ang_y", "u_ang_z", "u_lin_x", "u_lin_z",
                               "v_ang_x", "v_ang_y", "v_ang_z", "v_lin_y", "v_lin_z"};

    image_point_interaction_matrix u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Matrix predictor
    // ------------------------------------------------------------------

    // Clamp a wide value into the signed 32-bit range
    function automatic longint clamp_word(input longint v);
        if (v > W_MAX) begin
            return W_MAX;
        end else if (v < W_MIN) begin
            return W_MIN;
        end
        return v;
    endfunction

    // (n << FRAC) / z, truncated toward zero, then clamped; z is positive here
    function automatic longint scaled_quotient(input longint n, input longint z);
        return clamp_word((n * (longint'(1) << FRAC)) / z);
    endfunction

    function automatic t_matrix_word predict_matrix(input logic [31:0] px,
                                                    input logic [31:0] py,
                                                    input logic [31:0] pz,
                                                    input logic mode);
        t_matrix_word w;
        longint x, y, z, xy, xx, yy, inv, one;
        w   = '0;
        one = longint'(1) << FRAC;
        x   = longint'($signed(px));
        y   = longint'($signed(py));
        z   = longint'($signed(pz));
        if (z <= 0) begin
            // Non-positive depth: flag it and zero every entry
            w.depth_invalid = 1'b1;
        end else begin
            if (mode == MODE_CAMERA) begin
                x = scaled_quotient(x, z);
                y = scaled_quotient(y, z);
            end
            // Products shift right arithmetically: floor rounding
            xy  = (x * y) >>> FRAC;
            xx  = (x * x) >>> FRAC;
            yy  = (y * y) >>> FRAC;
            inv = clamp_word(-(one * one) / z);
            w.entry[0] = 32'(clamp_word(xy));
            w.entry[1] = 32'(clamp_word(-(one + xx)));
            w.entry[2] = 32'(y);
            w.entry[3] = 32'(inv);
            w.entry[4] = 32'(scaled_quotient(x, z));
            w.entry[5] = 32'(clamp_word(one + yy));
            w.entry[6] = 32'(clamp_word(-xy));
            w.entry[7] = 32'(clamp_word(-x));
            w.entry[8] = 32'(inv);
            w.entry[9] = 32'(scaled_quotient(y, z));
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------

    // Record each accepted point and predict its matrix on the spot, with the
    // mode that is in force (the mode only changes while nothing is in flight).
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            matrix_q.push_back(predict_matrix(i_s_tdata[31:0], i_s_tdata[63:32],
                                              i_s_tdata[95:64], mode_shadow));
            point_taken = 1'b1;
        end
    end

    // Advance on the falling edge: hold the word until it is taken, then wait
    // the drawn gap before presenting the next one. A back-to-back word keeps
    // tvalid high with a single assignment.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || point_taken)) begin
            point_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                i_s_tvalid <= 1'b0;
            end else if (point_q.size() != 0) begin
                i_s_tdata  <= point_q.pop_front();
                i_s_tvalid <= 1'b1;
                src_gap = src_idle_en ? $urandom_range(0, 3) : 0;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------

    // Compare each accepted word entry by entry with the oldest prediction
    always @(posedge i_clk) begin : check_matrix
        t_matrix_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            matrix_taken = 1'b1;
            if (matrix_q.size() == 0) begin
                report_mismatch("word with no prediction waiting", o_m_tdata[31:0], '0);
            end else begin
                want = matrix_q.pop_front();
                for (int k = 0; k < 10; k++) begin
                    if (o_m_tdata[k*DW +: DW] !== want.entry[k]) begin
                        report_mismatch(entry_name[k], o_m_tdata[k*DW +: DW], want.entry[k]);
                    end
                end
                if (o_m_tuser !== want.depth_invalid) begin
                    report_mismatch("depth_invalid", {31'b0, o_m_tuser},
                                    {31'b0, want.depth_invalid});
                end
            end
        end
    end

    // Draw a stall after every taken word; drop tready while it runs out
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (matrix_taken) begin
                matrix_taken = 1'b0;
                snk_stall = snk_idle_en ? $urandom_range(0, 3) : 0;
            end
            if (snk_stall > 0) begin
                snk_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic add_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        point_q.push_back({z, y, x});
    endtask

    // Extremes, saturation corners, smallest and largest depth, and the three
    // kinds of non-positive depth (zero, small negative, most negative)
    task automatic add_directed_points();
        add_point('0, '0, Q_ONE);
        add_point(Q_ONE + (Q_ONE >> 1), -(Q_ONE >> 2), Q_ONE << 1);
        add_point(-Q_ONE, Q_ONE, Q_ONE);
        add_point(Q_MAX, Q_MAX, Q_ONE);
        add_point(Q_MIN, Q_MIN, Q_ONE);
        add_point(Q_MIN, Q_MAX, Q_ONE);
        add_point(Q_MAX, Q_MIN, 32'd1);
        add_point(Q_MIN, Q_MAX, Q_MAX);
        add_point(Q_ONE, Q_ONE, '0);
        add_point(Q_ONE, -Q_ONE, 32'hFFFF_FFFF);
        add_point(Q_MAX, Q_MIN, Q_MIN);
        add_point(32'hFFFF_FFFF, 32'd1, Q_ONE >> 1);
    endtask

    // Mostly moderate coordinates so that products stay in range, with full
    // random words and values hugging the limits mixed in
    function automatic logic [31:0] rand_coord();
        unique case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2, 3, 4: return $urandom_range(0, 8 * 32'h1_0000) - 4 * 32'h1_0000;
            5:       return $urandom_range(0, 1) ? Q_MAX - $urandom_range(0, 15)
                                                 : Q_MIN + $urandom_range(0, 15);
            6:       return $urandom_range(0, 31) - 16;
            default: return $urandom_range(0, 512 * 32'h1_0000) - 256 * 32'h1_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_depth();
        unique case ($urandom_range(0, 9))
            0:       return $urandom | 32'h8000_0000;
            1:       return $urandom_range(0, 1) ? 32'd0 : 32'd0 - $urandom_range(1, 16);
            2, 3:    return $urandom & 32'h7FFF_FFFF;
            4:       return $urandom_range(1, 255);
            default: return $urandom_range(Q_ONE >> 3, Q_ONE << 4);
        endcase
    endfunction

    // Write the mode register; only called with the pipeline empty
    task automatic write_mode(input logic m);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_shadow = m;
    endtask

    // Hold until every point has gone in and every prediction has come back
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (point_q.size() != 0 || i_s_tvalid || matrix_q.size() != 0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(MODE_NORMALIZED);
        add_directed_points();
        wait_drained();

        write_mode(MODE_CAMERA);
        add_directed_points();
        wait_drained();

        // Random phases alternate the mode; phase 2 runs the source with no
        // gaps, phase 3 the sink with no stalls, phase 5 both at full rate.
        for (int phase = 0; phase < 6; phase++) begin
            src_idle_en = (phase != 2 && phase != 5);
            snk_idle_en = (phase != 3 && phase != 5);
            write_mode(phase[0] ? MODE_CAMERA : MODE_NORMALIZED);
            for (int n = 0; n < 240; n++) begin
                add_point(rand_coord(), rand_coord(), rand_depth());
            end
            wait_drained();
        end

        // Let any stray word show up before the verdict
        repeat (ipim_pkg::PIPE_LAT + 4) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule
